[sv/hcsm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcsm_pkg
// Types, codes and helpers shared by the header compressor state machine.
// ----------------------------------------------------------------------------
package hcsm_pkg;

    // Field widths
    localparam int KIND_W  = 4;
    localparam int MODE_W  = 2;
    localparam int RUN_W   = 8;
    localparam int TMO_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Compressor state codes
    localparam logic [MODE_W-1:0] PH_IR = 2'd0;
    localparam logic [MODE_W-1:0] PH_FO = 2'd1;
    localparam logic [MODE_W-1:0] PH_SO = 2'd2;

    // Packet type codes
    localparam logic [KIND_W-1:0] KIND_IR     = 4'd0;
    localparam logic [KIND_W-1:0] KIND_IR_DYN = 4'd1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IR_TIMEOUT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FO_TIMEOUT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IR_RUN_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FO_RUN_LIMIT = 2'd3;

    // Reset / fallback values
    localparam logic [TMO_W-1:0] DEF_IR_TIMEOUT = 16'd1024;
    localparam logic [TMO_W-1:0] DEF_FO_TIMEOUT = 16'd256;
    localparam logic [RUN_W-1:0] DEF_RUN_LIMIT  = 8'd3;

    // Machine state
    typedef struct packed {
        logic [MODE_W-1:0] phase;
        logic [RUN_W-1:0]  ir_run;
        logic [RUN_W-1:0]  fo_run;
        logic [TMO_W-1:0]  to_ir_count;
        logic [TMO_W-1:0]  to_fo_count;
    } hcsm_state_t;

    // Configuration registers
    typedef struct packed {
        logic [TMO_W-1:0] ir_timeout;
        logic [TMO_W-1:0] fo_timeout;
        logic [RUN_W-1:0] ir_run_limit;
        logic [RUN_W-1:0] fo_run_limit;
    } hcsm_cfg_t;

    // Saturating increments
    function automatic logic [RUN_W-1:0] sat_inc8(input logic [RUN_W-1:0] v);
        sat_inc8 = (v == {RUN_W{1'b1}}) ? v : v + RUN_W'(1);
    endfunction

    function automatic logic [TMO_W-1:0] sat_inc16(input logic [TMO_W-1:0] v);
        sat_inc16 = (v == {TMO_W{1'b1}}) ? v : v + TMO_W'(1);
    endfunction

endpackage : hcsm_pkg
`default_nettype wire

[sv/hcsm_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcsm_ifs
// Valid/ready channels for packet requests and packet decisions.
// ----------------------------------------------------------------------------
interface hcsm_req_if;
    logic                        valid;
    logic                        ready;
    logic [hcsm_pkg::KIND_W-1:0] fo_kind;
    logic [hcsm_pkg::KIND_W-1:0] so_kind;

    modport source (output valid, output fo_kind, output so_kind, input ready);
    modport sink   (input valid, input fo_kind, input so_kind, output ready);
endinterface : hcsm_req_if

interface hcsm_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [hcsm_pkg::KIND_W-1:0] packet_kind;
    logic [hcsm_pkg::MODE_W-1:0] mode_after;

    modport source (output valid, output packet_kind, output mode_after, input ready);
    modport sink   (input valid, input packet_kind, input mode_after, output ready);
endinterface : hcsm_rsp_if
`default_nettype wire

[sv/hcsm_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcsm_step
// Next-state and packet-type decision for one packet: periodic fallback,
// run-length promotion, then packet-type choice.
// ----------------------------------------------------------------------------
module hcsm_step (
    input  hcsm_pkg::hcsm_state_t           cur,
    input  hcsm_pkg::hcsm_cfg_t             cfg,
    input  logic [hcsm_pkg::KIND_W-1:0]     fo_kind,
    input  logic [hcsm_pkg::KIND_W-1:0]     so_kind,
    output hcsm_pkg::hcsm_state_t           nxt,
    output logic [hcsm_pkg::KIND_W-1:0]     packet_kind
);
    import hcsm_pkg::*;

    logic [TMO_W-1:0] eff_ir;
    logic [TMO_W-1:0] eff_fo;

    // Effective timeouts: fall back to defaults on an unusable pair
    always_comb
    begin
        if ((cfg.ir_timeout == '0) || (cfg.fo_timeout == '0) ||
            (cfg.ir_timeout <= cfg.fo_timeout))
        begin
            eff_ir = DEF_IR_TIMEOUT;
            eff_fo = DEF_FO_TIMEOUT;
        end
        else
        begin
            eff_ir = cfg.ir_timeout;
            eff_fo = cfg.fo_timeout;
        end
    end

    // Three decision steps in sequence
    always_comb
    begin
        hcsm_state_t      s;
        logic [MODE_W-1:0] p;

        s = cur;

        // periodic fallback
        p = s.phase;
        if (s.to_ir_count >= eff_ir)
        begin
            s.to_ir_count = '0;
            p = PH_IR;
        end
        else if (s.to_fo_count >= eff_fo)
        begin
            s.to_fo_count = '0;
            if (s.phase != PH_IR)
                p = PH_FO;
        end
        if (p != s.phase)
        begin
            s.ir_run = '0;
            s.fo_run = '0;
            s.phase  = p;
        end
        if ((s.phase != PH_IR) && (s.phase != PH_FO))
            s.to_fo_count = sat_inc16(s.to_fo_count);
        if (s.phase != PH_IR)
            s.to_ir_count = sat_inc16(s.to_ir_count);

        // run-length promotion
        if ((s.phase == PH_IR) && (s.ir_run >= cfg.ir_run_limit))
        begin
            s.phase  = PH_FO;
            s.ir_run = '0;
            s.fo_run = '0;
        end
        else if ((s.phase == PH_FO) && (s.fo_run >= cfg.fo_run_limit))
        begin
            s.phase  = PH_SO;
            s.ir_run = '0;
            s.fo_run = '0;
        end

        // packet-type choice; IR_DYN in SO demotes to FO
        if (s.phase == PH_IR)
        begin
            s.ir_run    = sat_inc8(s.ir_run);
            packet_kind = KIND_IR;
        end
        else if (s.phase == PH_FO)
        begin
            s.fo_run    = sat_inc8(s.fo_run);
            packet_kind = fo_kind;
        end
        else
        begin
            packet_kind = so_kind;
            if (so_kind == KIND_IR_DYN)
            begin
                s.phase  = PH_FO;
                s.ir_run = '0;
                s.fo_run = '0;
            end
        end

        nxt = s;
    end

endmodule : hcsm_step
`default_nettype wire

[sv/header_compressor_state_machine_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// header_compressor_state_machine_unit
// IR/FO/SO compressor state machine: one packet decision per transfer.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake     Payload
//  req       in   valid/ready   fo_kind[3:0], so_kind[3:0]
//  rsp       out  valid/ready   packet_kind[3:0], mode_after[1:0]
//  cfg       in   cfg_we        cfg_index[1:0], cfg_wdata[15:0]
//
//  One request per cycle while req.ready is high; its decision appears on
//  rsp the next cycle. The result register is the only stage: state
//  advances at the request transfer, so throughput is one packet per clock
//  unless rsp stalls. req.ready is low only while a result is held and
//  rsp.ready is low. Reset puts the machine in IR with all counters
//  cleared and the configuration registers at their defaults.
// ----------------------------------------------------------------------------
module header_compressor_state_machine_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    hcsm_req_if.sink                          req,
    hcsm_rsp_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [hcsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hcsm_pkg::CFG_W-1:0]        cfg_wdata
);
    import hcsm_pkg::*;

    hcsm_cfg_t         cfg_reg;
    hcsm_state_t       state_reg;
    hcsm_state_t       state_next;
    logic [KIND_W-1:0] kind_next;
    logic [KIND_W-1:0] kind_reg;
    logic [MODE_W-1:0] mode_reg;
    logic              valid_reg;
    logic              req_xfer;

    assign req.ready = !valid_reg || rsp.ready;
    assign req_xfer  = req.valid && req.ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ir_timeout   <= DEF_IR_TIMEOUT;
            cfg_reg.fo_timeout   <= DEF_FO_TIMEOUT;
            cfg_reg.ir_run_limit <= DEF_RUN_LIMIT;
            cfg_reg.fo_run_limit <= DEF_RUN_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IR_TIMEOUT:   cfg_reg.ir_timeout   <= cfg_wdata;
                REG_FO_TIMEOUT:   cfg_reg.fo_timeout   <= cfg_wdata;
                REG_IR_RUN_LIMIT: cfg_reg.ir_run_limit <= cfg_wdata[RUN_W-1:0];
                REG_FO_RUN_LIMIT: cfg_reg.fo_run_limit <= cfg_wdata[RUN_W-1:0];
                default:          ;
            endcase
        end
    end

    // Decision logic
    hcsm_step u_step (
        .cur         (state_reg),
        .cfg         (cfg_reg),
        .fo_kind     (req.fo_kind),
        .so_kind     (req.so_kind),
        .nxt         (state_next),
        .packet_kind (kind_next)
    );

    // Machine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (req_xfer)
            state_reg <= state_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (req.ready)
            valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            kind_reg <= kind_next;
            mode_reg <= state_next.phase;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.packet_kind = kind_reg;
    assign rsp.mode_after  = mode_reg;

endmodule : header_compressor_state_machine_unit
`default_nettype wire
